// File: hdl/bcd_pkg.sv
package bcd_pkg;

    // Timer and field widths.
    localparam int TIMER_WIDTH = 16;
    localparam int DT_WIDTH    = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int SUM_WIDTH   = ((TIMER_WIDTH > DT_WIDTH) ? TIMER_WIDTH : DT_WIDTH) + 1;

    typedef logic [TIMER_WIDTH-1:0] timer_t;
    typedef logic [DT_WIDTH-1:0]    dt_t;
    typedef logic [CFG_WIDTH-1:0]   cfg_word_t;

    localparam timer_t TIMER_MAX = {TIMER_WIDTH{1'b1}};

    // Defaults that replace a register value of zero, and the click count limit.
    localparam cfg_word_t DEF_DEBOUNCE = 16'd20;
    localparam cfg_word_t DEF_LONG     = 16'd800;
    localparam cfg_word_t DEF_GAP      = 16'd250;
    localparam logic [1:0] MAX_CLICKS  = 2'd2;

    // Queue between the front and the back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [2:0] {
        EV_DOWN   = 3'd0,
        EV_UP     = 3'd1,
        EV_LONG   = 3'd2,
        EV_SINGLE = 3'd3,
        EV_DOUBLE = 3'd4
    } event_code_t;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_RESYNC = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_PRESS_LEVEL     = 2'd0,
        CFG_DEBOUNCE_TIME   = 2'd1,
        CFG_LONG_PRESS_TIME = 2'd2,
        CFG_CLICK_GAP_TIME  = 2'd3
    } cfg_index_t;

    // Configuration register set.
    typedef struct packed {
        logic      press_level;
        cfg_word_t debounce_time;
        cfg_word_t long_press_time;
        cfg_word_t click_gap_time;
    } cfg_t;

    // One queue entry holds the one or two events of a tick.
    typedef struct packed {
        logic        two;
        event_code_t ev0;
        event_code_t ev1;
    } fifo_entry_t;

    // Saturating timer add.
    function automatic timer_t add_sat(timer_t t, dt_t inc);
        logic [SUM_WIDTH-1:0] s;
        s = SUM_WIDTH'(t) + SUM_WIDTH'(inc);
        if (s > SUM_WIDTH'(TIMER_MAX))
        begin
            return TIMER_MAX;
        end
        return timer_t'(s);
    endfunction

    // True when the timer has reached the threshold, zero meaning the default.
    function automatic logic reached(timer_t t, cfg_word_t v, cfg_word_t dflt);
        cfg_word_t limit;
        limit = (v == '0) ? dflt : v;
        return SUM_WIDTH'(t) >= SUM_WIDTH'(limit);
    endfunction

endpackage

// File: hdl/bcd_front.sv
module bcd_front
    import bcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic        raw_level,
    input  logic [15:0] elapsed_time,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        fifo_full,
    output logic        push,
    output fifo_entry_t push_data
);

    cfg_t        cfg_reg;
    logic        deb_reg, deb_next;
    logic        prev_reg, prev_next;
    timer_t      steady_reg, steady_next;
    timer_t      hold_reg, hold_next;
    timer_t      gap_reg, gap_next;
    logic [1:0]  clicks_reg, clicks_next;
    logic        long_reg, long_next;
    logic        raw;
    logic [1:0]  n;
    event_code_t ev0, ev1;
    logic        accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !fifo_full;
    assign accept    = in_valid && in_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_level     <= 1'b0;
            cfg_reg.debounce_time   <= DEF_DEBOUNCE;
            cfg_reg.long_press_time <= DEF_LONG;
            cfg_reg.click_gap_time  <= DEF_GAP;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PRESS_LEVEL:     cfg_reg.press_level     <= cfg_data[0];
                CFG_DEBOUNCE_TIME:   cfg_reg.debounce_time   <= cfg_data;
                CFG_LONG_PRESS_TIME: cfg_reg.long_press_time <= cfg_data;
                CFG_CLICK_GAP_TIME:  cfg_reg.click_gap_time  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Debounce, hold and gap evaluation of one tick, or a resync of the button state.
    always_comb
    begin
        raw         = (raw_level == cfg_reg.press_level);
        deb_next    = deb_reg;
        prev_next   = prev_reg;
        steady_next = steady_reg;
        hold_next   = hold_reg;
        gap_next    = gap_reg;
        clicks_next = clicks_reg;
        long_next   = long_reg;
        n           = 2'd0;
        ev0         = EV_DOWN;
        ev1         = EV_DOWN;

        if (opcode == OP_RESYNC)
        begin
            deb_next    = raw;
            prev_next   = raw;
            steady_next = '0;
            hold_next   = '0;
            gap_next    = '0;
            clicks_next = '0;
            long_next   = 1'b0;
        end
        else
        begin
            if (raw != prev_reg)
            begin
                prev_next   = raw;
                steady_next = '0;
            end
            else
            begin
                steady_next = add_sat(steady_reg, elapsed_time);
                if (reached(steady_next, cfg_reg.debounce_time, DEF_DEBOUNCE)
                    && (deb_reg != raw))
                begin
                    deb_next = raw;
                    n        = 2'd1;
                    if (raw)
                    begin
                        hold_next = '0;
                        long_next = 1'b0;
                        ev0       = EV_DOWN;
                    end
                    else
                    begin
                        ev0 = EV_UP;
                        if (!long_reg)
                        begin
                            if (clicks_reg < MAX_CLICKS)
                            begin
                                clicks_next = clicks_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            clicks_next = '0;
                        end
                        gap_next = '0;
                    end
                end
            end

            // A long press while held, or the end of a click sequence while released.
            if (deb_next)
            begin
                hold_next = add_sat(hold_next, elapsed_time);
                if (!long_next && reached(hold_next, cfg_reg.long_press_time, DEF_LONG))
                begin
                    long_next   = 1'b1;
                    clicks_next = '0;
                    gap_next    = '0;
                    if (n == 2'd0)
                    begin
                        ev0 = EV_LONG;
                    end
                    else
                    begin
                        ev1 = EV_LONG;
                    end
                    n = n + 2'd1;
                end
            end
            else if (clicks_next != '0)
            begin
                gap_next = add_sat(gap_next, elapsed_time);
                if (reached(gap_next, cfg_reg.click_gap_time, DEF_GAP))
                begin
                    if (n == 2'd0)
                    begin
                        ev0 = (clicks_next >= MAX_CLICKS) ? EV_DOUBLE : EV_SINGLE;
                    end
                    else
                    begin
                        ev1 = (clicks_next >= MAX_CLICKS) ? EV_DOUBLE : EV_SINGLE;
                    end
                    n           = n + 2'd1;
                    clicks_next = '0;
                    gap_next    = '0;
                end
            end
        end
    end

    assign push          = accept && (n != 2'd0);
    assign push_data.two = (n == 2'd2);
    assign push_data.ev0 = ev0;
    assign push_data.ev1 = ev1;

    // Button state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_reg    <= 1'b0;
            prev_reg   <= 1'b0;
            steady_reg <= '0;
            hold_reg   <= '0;
            gap_reg    <= '0;
            clicks_reg <= '0;
            long_reg   <= 1'b0;
        end
        else if (accept)
        begin
            deb_reg    <= deb_next;
            prev_reg   <= prev_next;
            steady_reg <= steady_next;
            hold_reg   <= hold_next;
            gap_reg    <= gap_next;
            clicks_reg <= clicks_next;
            long_reg   <= long_next;
        end
    end

endmodule

// File: hdl/bcd_fifo.sv
module bcd_fifo
    import bcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  fifo_entry_t push_data,
    output logic        full,
    input  logic        pop,
    output fifo_entry_t head,
    output logic        empty
);

    fifo_entry_t        mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    assign full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hdl/bcd_back.sv
module bcd_back
    import bcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  fifo_entry_t head,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_code,
    output logic        last_event
);

    logic sel_reg, sel_next;

    // Walk through the one or two events of the head entry.
    assign out_valid  = !empty;
    assign event_code = sel_reg ? head.ev1 : head.ev0;
    assign last_event = sel_reg || !head.two;
    assign pop        = out_valid && out_ready && last_event;

    always_comb
    begin
        sel_next = sel_reg;
        if (out_valid && out_ready)
        begin
            sel_next = !last_event;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
        end
        else
        begin
            sel_reg <= sel_next;
        end
    end

endmodule

// File: hdl/button_click_detector_top.sv
// A tick whose events enter an empty queue shows its first event in the next cycle.
// Throughput: one tick item per cycle while the queue is not full; events leave at one per
// cycle while out_ready is high, so a tick with two events holds the output for both, and a
// four-entry queue absorbs the difference. Input ready drops only when that queue is full.
// Reset (rst_n, asynchronous, active low) clears all button state and the queue and loads
// the default configuration: active level 0, debounce 20, long press 800, click gap 250.
module button_click_detector_top
    import bcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic        raw_level,
    input  logic [15:0] elapsed_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_code,
    output logic        last_event,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    fifo_entry_t push_data, head;
    logic        push, pop, full, empty;

    // Front: configuration and per-tick evaluation.
    bcd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .raw_level    (raw_level),
        .elapsed_time (elapsed_time),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fifo_full    (full),
        .push         (push),
        .push_data    (push_data)
    );

    // Event queue.
    bcd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    // Back: serializes events onto the output channel.
    bcd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_code (event_code),
        .last_event (last_event)
    );

    // The queue is never written while full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("event queue written while full");

    // A resync item never produces an event.
    a_resync_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (opcode == OP_RESYNC)) |-> !push)
        else $error("resync item produced an event");

    // An item that pushes into an empty queue shows up on the output next cycle.
    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (push && empty) |=> out_valid)
        else $error("pushed event not visible on the output");

endmodule
